// File: design/asa_pkg.sv
// Package for the anti-aliased span accumulator.
// Holds the default sizes, the payload structs and the per-pixel token type.
package asa_pkg;

  localparam int MAX_WIDTH_DEF       = 64;
  localparam int MAX_HEIGHT_DEF      = 64;
  localparam int SUBSAMPLE_SHIFT_DEF = 2;

  localparam logic [6:0] WIDTH_RESET = 7'd64;

  // Coverage weights: full sample and the one reduced corner of the table.
  localparam logic [7:0] COVER_FULL  = 8'h10;
  localparam logic [7:0] COVER_SHORT = 8'h0f;
  // Table row whose first column carries the reduced weight.
  localparam logic [1:0] SHORT_ROW   = 2'd2;

  typedef struct packed {
    logic [9:0]         sample_row_y;
    logic signed [15:0] span_left;
    logic signed [15:0] span_right;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pixel_column;
    logic [5:0] pixel_row;
    logic [7:0] alpha_value;
    logic       last_pixel;
  } out_item_t;

  // One pixel on its way through the read-modify-write chain.
  typedef struct packed {
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] val;
    logic       last;
  } token_t;

endpackage

// File: design/antialiased_span_accumulate.sv
// Anti-aliased span accumulator, top level: span walker, pixel chain, alpha store.
// Pixels pass the walker register, the first chain cell and the output cell, one pixel per cycle;
// busy stays high while the walker or the first cell holds a pixel (one RAM read-modify-write each).
// Empty or out-of-store spans are dropped in the accept cycle and emit nothing.
// After reset the alpha store is cleared, one entry a cycle, all MAX_WIDTH*MAX_HEIGHT
// entries (4096 by default) with busy high; the receiver cannot stall results.
module antialiased_span_accumulate
  import asa_pkg::*;
#(
  parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
  parameter int SUBSAMPLE_SHIFT = SUBSAMPLE_SHIFT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [6:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [6:0]  MW7  = 7'(MAX_WIDTH);
  localparam logic [10:0] MH11 = 11'(MAX_HEIGHT);
  localparam logic [AW:0] DEPTH_LAST = (AW+1)'(DEPTH - 1);

  // Configuration and clearing pass.
  logic [6:0]  width_r;
  logic        clearing_r;
  logic [AW:0] clr_cnt_r;

  // Span walker.
  logic       active_r, active_nxt;
  logic [5:0] px_r, px_nxt;
  logic [8:0] l_r, l_nxt, r_r, r_nxt;
  logic [5:0] row_r, row_nxt;
  logic       short_r, short_nxt;

  logic       accept;
  logic [6:0] wlim;
  logic signed [17:0] left_c, right_c, lim, lsc, rsc;
  logic       empty, row_bad;
  logic [5:0] row_in;

  logic [8:0] base, top_px, lo, hi, span_n;
  logic       is_last;
  token_t     walk_tok;

  logic       c0_valid, c1_valid;
  token_t     c0_tok, c1_tok, sum_tok;
  logic [7:0] rdata;
  logic [8:0] sum;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata;

  assign busy   = clearing_r || active_r || c0_valid;
  assign accept = start && !busy;

  // Register write and post-reset clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_data;
      end
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == DEPTH_LAST) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  // Clip both edges and snap them to sample columns: col = (f + 1) >>> 2.
  always_comb begin
    wlim    = (width_r > MW7) ? MW7 : width_r;
    lim     = signed'(18'({wlim, 4'b0000}));
    left_c  = (in_item.span_left < 0) ? 18'sd0 : 18'(in_item.span_left);
    right_c = (18'(in_item.span_right) > lim) ? lim : 18'(in_item.span_right);
    lsc     = (left_c + 18'sd1) >>> SUBSAMPLE_SHIFT;
    rsc     = (right_c + 18'sd1) >>> SUBSAMPLE_SHIFT;
    empty   = (rsc <= lsc);
    row_in  = in_item.sample_row_y[9:4];
    row_bad = (11'(row_in) >= MH11);
  end

  // Walker next state: load a span, then step one pixel per cycle.
  always_comb begin
    active_nxt = active_r;
    px_nxt     = px_r;
    l_nxt      = l_r;
    r_nxt      = r_r;
    row_nxt    = row_r;
    short_nxt  = short_r;
    if (accept) begin
      active_nxt = !empty && !row_bad;
      l_nxt      = lsc[8:0];
      r_nxt      = rsc[8:0];
      px_nxt     = lsc[7:2];
      row_nxt    = row_in;
      short_nxt  = (in_item.sample_row_y[3:2] == SHORT_ROW);
    end else if (active_r) begin
      px_nxt = px_r + 1'b1;
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    px_r    <= px_nxt;
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    row_r   <= row_nxt;
    short_r <= short_nxt;
  end

  // Covered samples of the current pixel and its weight.
  always_comb begin
    base     = {1'b0, px_r, 2'b00};
    top_px   = base + 9'd4;
    lo       = (l_r > base) ? l_r : base;
    hi       = (r_r < top_px) ? r_r : top_px;
    span_n   = hi - lo;
    is_last  = (top_px >= r_r);
    walk_tok.col  = px_r;
    walk_tok.row  = row_r;
    walk_tok.val  = 8'({span_n[2:0], 4'b0000}) - {7'd0, short_r};
    walk_tok.last = is_last;
  end

  assign ram_raddr = AW'(row_r * MAX_WIDTH + px_r);

  // First cell lines the token up with the registered read data.
  asa_cell u_cell0 (
    .clk, .rst_n,
    .in_valid(active_r), .in_tok(walk_tok),
    .out_valid(c0_valid), .out_tok(c0_tok)
  );

  // Saturating add of the weight into the stored alpha.
  always_comb begin
    sum         = {1'b0, rdata} + {1'b0, c0_tok.val};
    sum_tok     = c0_tok;
    sum_tok.val = sum[8] ? 8'hff : sum[7:0];
  end

  // Second cell is the output register.
  asa_cell u_cell1 (
    .clk, .rst_n,
    .in_valid(c0_valid), .in_tok(sum_tok),
    .out_valid(c1_valid), .out_tok(c1_tok)
  );

  // Write port: clearing pass first, then the updated alpha.
  always_comb begin
    ram_we    = clearing_r || c0_valid;
    ram_waddr = clearing_r ? clr_cnt_r[AW-1:0] : AW'(c0_tok.row * MAX_WIDTH + c0_tok.col);
    ram_wdata = clearing_r ? 8'd0 : sum_tok.val;
  end

  asa_ram #(.W(8), .DEPTH(DEPTH)) u_store (
    .clk,
    .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rdata)
  );

  assign out_valid             = c1_valid;
  assign out_item.pixel_column = c1_tok.col;
  assign out_item.pixel_row    = c1_tok.row;
  assign out_item.alpha_value  = c1_tok.val;
  assign out_item.last_pixel   = c1_tok.last;

  // A token in the first cell always reaches the output next cycle.
  a_chain: assert property (@(posedge clk) disable iff (!rst_n) c0_valid |=> out_valid)
    else $error("pixel token lost in chain");
  // No pixel work overlaps the clearing pass.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!active_r && !c0_valid && !out_valid))
    else $error("pixel work during clearing");
  // A finished span leaves the walker idle until the next transfer.
  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && is_last) |=> (!active_r && c0_valid && c0_tok.last))
    else $error("walker did not stop on last pixel");

endmodule

// File: design/asa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module asa_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/asa_cell.sv
// One cell of the pixel chain: holds a token and hands it on each cycle.
// Depends on asa_pkg for the token type.
module asa_cell
  import asa_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  token_t in_tok,
  output logic   out_valid,
  output token_t out_tok
);

  logic   valid_r;
  token_t tok_r;

  // Valid bit is control state; the token itself needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    tok_r <= in_tok;
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;

endmodule

// File: sim/span_checker.sv
// Checker for the anti-aliased span accumulator: watches the span, result and width ports.
// Keeps its own alpha store and width copy; depends on asa_pkg for the payload types.
module span_checker
  import asa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic [6:0] cfg_data,
  output int        pixels_pending,
  output int        mismatch_count
);

  logic [7:0]  alpha_copy [64*64];
  logic [6:0]  width_copy;
  out_item_t   pixel_queue [$];

  assign pixels_pending = pixel_queue.size();

  // Snap a 12.4 edge up to the next sample centre and return its sample column.
  function automatic int snap_column(int f);
    int g;
    g = ((f + 65537) & ~3) + 2;
    return (g >>> 2) - 16384;
  endfunction

  // Work out the pixels one span updates and fold them into the alpha copy.
  function automatic void accumulate_span(in_item_t it);
    int y, left, right, row, l, r, x, px, w, full, c, wlim, a;
    int cols [$];
    int wts [$];
    logic [7:0] cov [4];
    out_item_t pix;
    y = it.sample_row_y;
    left = it.span_left;
    right = it.span_right;
    row = y >> 4;
    if (row >= 64) return;
    for (c = 0; c < 4; c++) cov[c] = COVER_FULL;
    if (((y >> 2) & 3) == SHORT_ROW) cov[0] = COVER_SHORT;
    wlim = (width_copy > 64) ? 64 : width_copy;
    if (left < 0) left = 0;
    if (right > wlim * 16) right = wlim * 16;
    l = snap_column(left);
    r = snap_column(right);
    if (r <= l) return;
    x = l;
    px = l >> 2;
    // Partial first pixel takes weights from the start of the table row.
    if (x & 3) begin
      w = 0;
      c = 0;
      while (x < r && (x & 3)) begin
        w += cov[c & 3];
        c++;
        x++;
      end
      cols.push_back(px);
      wts.push_back(w);
      px++;
    end
    full = cov[0] + cov[1] + cov[2] + cov[3];
    while (x + 3 < r) begin
      cols.push_back(px);
      wts.push_back(full);
      px++;
      x += 4;
    end
    // Partial last pixel, only when the right end lies inside a pixel.
    if ((r & 3) && x < r) begin
      w = 0;
      c = 0;
      while (x < r) begin
        w += cov[c & 3];
        c++;
        x++;
      end
      cols.push_back(px);
      wts.push_back(w);
    end
    c = 0;
    foreach (cols[k]) begin
      if (cols[k] < 64 && c < 64) begin
        a = alpha_copy[row * 64 + cols[k]] + wts[k];
        if (a > 255) a = 255;
        alpha_copy[row * 64 + cols[k]] = a[7:0];
        pix.pixel_column = cols[k][5:0];
        pix.pixel_row = row[5:0];
        pix.alpha_value = a[7:0];
        pix.last_pixel = 1'b0;
        pixel_queue.push_back(pix);
        c++;
      end
    end
    if (c > 0) pixel_queue[pixel_queue.size() - 1].last_pixel = 1'b1;
  endfunction

  // Sample every channel at the rising edge, before the block's outputs move.
  always @(posedge clk) begin
    out_item_t exp_pix;
    if (!rst_n) begin
      foreach (alpha_copy[i]) alpha_copy[i] = 8'd0;
      width_copy = WIDTH_RESET;
      pixel_queue.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid) begin
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %p", $time, out_item);
          mismatch_count++;
        end else begin
          exp_pix = pixel_queue.pop_front();
          if (exp_pix !== out_item) begin
            $display("%0t: pixel mismatch, expected %p, actual %p", $time, exp_pix, out_item);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) accumulate_span(in_item);
      if (cfg_we) width_copy = cfg_data;
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the anti-aliased span accumulator: clock, reset, span stimulus, verdict.
// Depends on asa_pkg, the block itself and span_checker.
module tb_top;
  import asa_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;
  int         pixels_pending;
  int         mismatch_count;
  int         idle_cycles = 0;

  always #5 clk = ~clk;

  antialiased_span_accumulate DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  span_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .pixels_pending(pixels_pending), .mismatch_count(mismatch_count)
  );

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Present one span and hold it until busy is sampled low.
  task automatic send_span(input int y, input int left, input int right);
    start <= 1'b1;
    in_item <= '{sample_row_y: y[9:0], span_left: left[15:0], span_right: right[15:0]};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Wait until every predicted pixel is out and the block is idle.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_width(input logic [6:0] w);
    cfg_we <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random spans in bursts with gaps; most spans are small and well formed.
  task automatic random_spans(input int count);
    int burst, gap, y, left, right;
    while (count > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && count > 0) begin
        if ($urandom_range(0, 1)) y = $urandom_range(0, 63);
        else y = $urandom_range(0, 1023);
        if ($urandom_range(0, 3) != 0) begin
          left = $urandom_range(0, 1100) - 60;
          right = left + $urandom_range(0, 320);
        end else begin
          left = $urandom_range(0, 65535);
          right = $urandom_range(0, 65535);
        end
        send_span(y, left, right);
        burst--;
        count--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed spans at the reset width.
    send_span(0, 0, 1024);
    send_span(8, 0, 1024);
    send_span(1023, -32768, 32767);
    send_span(520, 5, 9);
    send_span(520, 5, 60);
    send_span(8, 33, 111);
    send_span(100, 20, 10);
    send_span(100, 40, 41);
    send_span(100, -40, -1);
    send_span(200, 2000, 3000);
    send_span(8, 17, 18);
    send_span(300, 0, 16);
    send_span(300, 14, 50);
    for (i = 0; i < 10; i++) send_span(8, 0, 1024);
    drain();

    // Several width settings, the extremes among them.
    write_width(7'd1);
    send_span(40, -100, 500);
    send_span(40, 3, 14);
    random_spans(30);
    drain();
    write_width(7'd0);
    send_span(40, -100, 500);
    random_spans(15);
    drain();
    write_width(7'd127);
    random_spans(40);
    drain();
    write_width(7'($urandom_range(1, 64)));
    random_spans(50);
    drain();
    write_width(7'd64);
    random_spans(65);
    drain();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
